/* hw/rtl/imu_tsd_pkg.sv */
// ----------------------------------------------------------------------------
// IMU step detector package
// Shared types, constants and helper functions of the step detector.
// ----------------------------------------------------------------------------
package imu_tsd_pkg;

  localparam int SampleBits = 16;
  localparam int SqBits     = 2 * SampleBits + 2;
  localparam int ThrBits    = 15;
  localparam int ThrSqBits  = 2 * ThrBits;
  localparam int CmpBits    = (SqBits > ThrSqBits) ? SqBits : ThrSqBits;
  localparam int CountBits  = 20;
  localparam int TimeBits   = 32;
  localparam int DelayBits  = 16;
  localparam int LengthBits = 12;
  localparam int IntvBits   = 16;
  localparam int DistBits   = 32;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;

  localparam logic [CountBits-1:0] StepMax = CountBits'(1000000);

  typedef enum logic [CfgIdxBits-1:0] {
    CfgAccThreshold = 3'd0,
    CfgAccRearm     = 3'd1,
    CfgGyroLimit    = 3'd2,
    CfgStepDelay    = 3'd3,
    CfgStepLength   = 3'd4,
    CfgSaveInterval = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                         cmd;
    logic signed [SampleBits-1:0] acc_x;
    logic signed [SampleBits-1:0] acc_y;
    logic signed [SampleBits-1:0] acc_z;
    logic signed [SampleBits-1:0] gyro_x;
    logic signed [SampleBits-1:0] gyro_y;
    logic signed [SampleBits-1:0] gyro_z;
    logic [TimeBits-1:0]          now_ms;
  } sample_t;

  typedef struct packed {
    logic                 step_seen;
    logic [CountBits-1:0] step_total;
    logic [DistBits-1:0]  distance_mm;
    logic                 save_request;
  } result_t;

  typedef struct packed {
    logic [ThrBits-1:0]    acc_threshold;
    logic [ThrBits-1:0]    acc_rearm_level;
    logic [ThrBits-1:0]    gyro_limit;
    logic [DelayBits-1:0]  step_delay_ms;
    logic [LengthBits-1:0] step_length_mm;
    logic [IntvBits-1:0]   save_interval;
  } cfg_t;

  typedef struct packed {
    logic                cmd;
    logic                acc_hi;
    logic                gyr_lo;
    logic                acc_lo;
    logic [TimeBits-1:0] now_ms;
  } flag_t;

  typedef struct packed {
    logic                 step_seen;
    logic [CountBits-1:0] step_total;
    logic                 save_request;
  } count_t;

  function automatic logic [SampleBits-1:0] sample_abs(input logic [SampleBits-1:0] v);
    logic [SampleBits-1:0] r;
    r = v[SampleBits-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  function automatic logic [2*SampleBits-1:0] sample_sq(input logic [SampleBits-1:0] v);
    logic [2*SampleBits-1:0] a;
    a = (2*SampleBits)'(sample_abs(v));
    return a * a;
  endfunction

endpackage

/* hw/rtl/imu_tsd_if.sv */
// ----------------------------------------------------------------------------
// IMU step detector channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface imu_tsd_sample_if;
  logic                  valid;
  logic                  ready;
  imu_tsd_pkg::sample_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface imu_tsd_result_if;
  logic                  valid;
  logic                  ready;
  imu_tsd_pkg::result_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface imu_tsd_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [imu_tsd_pkg::CfgIdxBits-1:0]         index;
  logic [imu_tsd_pkg::CfgDataBits-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/imu_tsd_mag.sv */
// ----------------------------------------------------------------------------
// IMU step detector magnitude pipeline
// Registers the sample, forms squared magnitudes and compares them with the
// squared thresholds.
// ----------------------------------------------------------------------------
module imu_tsd_mag (
  input  logic                clk_i,
  input  logic                rst_ni,
  imu_tsd_sample_if.sink      sample_if,
  input  imu_tsd_pkg::cfg_t   cfg_i,
  output logic                flag_valid_o,
  input  logic                flag_ready_i,
  output imu_tsd_pkg::flag_t  flag_o
);
  import imu_tsd_pkg::*;

  logic                v1_q, v2_q, v3_q;
  logic                en1, en2, en3;
  sample_t             item1_q;
  logic                cmd2_q;
  logic [TimeBits-1:0] now2_q;
  logic [SqBits-1:0]   acc_sq2_q, gyr_sq2_q;
  logic [SqBits-1:0]   acc_sq_d, gyr_sq_d;
  logic [ThrSqBits-1:0] thr_sq_q, rearm_sq_q, lim_sq_q;
  flag_t               flag3_q, flag3_d;

  assign en3 = !v3_q || flag_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign sample_if.ready = en1;

  assign acc_sq_d = SqBits'(sample_sq(item1_q.acc_x)) + SqBits'(sample_sq(item1_q.acc_y))
                  + SqBits'(sample_sq(item1_q.acc_z));
  assign gyr_sq_d = SqBits'(sample_sq(item1_q.gyro_x)) + SqBits'(sample_sq(item1_q.gyro_y))
                  + SqBits'(sample_sq(item1_q.gyro_z));

  always_comb begin
    flag3_d.cmd    = cmd2_q;
    flag3_d.now_ms = now2_q;
    flag3_d.acc_hi = CmpBits'(acc_sq2_q) > CmpBits'(thr_sq_q);
    flag3_d.gyr_lo = CmpBits'(gyr_sq2_q) < CmpBits'(lim_sq_q);
    flag3_d.acc_lo = CmpBits'(acc_sq2_q) < CmpBits'(rearm_sq_q);
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q   <= ThrSqBits'(cfg_i.acc_threshold) * ThrSqBits'(cfg_i.acc_threshold);
    rearm_sq_q <= ThrSqBits'(cfg_i.acc_rearm_level) * ThrSqBits'(cfg_i.acc_rearm_level);
    lim_sq_q   <= ThrSqBits'(cfg_i.gyro_limit) * ThrSqBits'(cfg_i.gyro_limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= sample_if.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && sample_if.valid) item1_q <= sample_if.payload;
    if (en2 && v1_q) begin
      cmd2_q    <= item1_q.cmd;
      now2_q    <= item1_q.now_ms;
      acc_sq2_q <= acc_sq_d;
      gyr_sq2_q <= gyr_sq_d;
    end
    if (en3 && v2_q) flag3_q <= flag3_d;
  end

  assign flag_valid_o = v3_q;
  assign flag_o       = flag3_q;

endmodule

/* hw/rtl/imu_tsd_core.sv */
// ----------------------------------------------------------------------------
// IMU step detector decision stage
// Holds the step state, decides steps and save requests for each request.
// ----------------------------------------------------------------------------
module imu_tsd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imu_tsd_pkg::cfg_t   cfg_i,
  input  logic                flag_valid_i,
  output logic                flag_ready_o,
  input  imu_tsd_pkg::flag_t  flag_i,
  output logic                cnt_valid_o,
  input  logic                cnt_ready_i,
  output imu_tsd_pkg::count_t cnt_o
);
  import imu_tsd_pkg::*;

  logic                 v_q;
  count_t               res_q, res_d;
  logic [CountBits-1:0] cnt_q, cnt_d, saved_q, saved_d, cnt_inc, diff;
  logic [TimeBits-1:0]  last_q, last_d, elapsed;
  logic                 latch_q, latch_d;
  logic                 step, save_ok, take;

  assign flag_ready_o = !v_q || cnt_ready_i;
  assign take         = flag_valid_i && flag_ready_o;

  assign elapsed = flag_i.now_ms - last_q;
  assign step    = !latch_q && flag_i.acc_hi && flag_i.gyr_lo
                && (elapsed > TimeBits'(cfg_i.step_delay_ms));
  assign cnt_inc = (cnt_q < StepMax) ? cnt_q + 1'b1 : cnt_q;
  assign diff    = cnt_inc - saved_q;
  assign save_ok = (cnt_inc != '0) && (cnt_inc >= saved_q)
                && (diff >= CountBits'(cfg_i.save_interval));

  always_comb begin
    cnt_d   = cnt_q;
    saved_d = saved_q;
    last_d  = last_q;
    latch_d = latch_q;
    res_d.step_seen    = 1'b0;
    res_d.save_request = 1'b0;
    if (flag_i.cmd) begin
      cnt_d   = '0;
      saved_d = '0;
      res_d.save_request = 1'b1;
    end else begin
      if (step) begin
        res_d.step_seen = 1'b1;
        cnt_d   = cnt_inc;
        last_d  = flag_i.now_ms;
        latch_d = 1'b1;
        if (save_ok) begin
          res_d.save_request = 1'b1;
          saved_d = cnt_inc;
        end
      end
      if (flag_i.acc_lo) latch_d = 1'b0;
    end
    res_d.step_total = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      cnt_q   <= '0;
      saved_q <= '0;
      last_q  <= '0;
      latch_q <= 1'b0;
    end else begin
      if (flag_ready_o) v_q <= flag_valid_i;
      if (take) begin
        cnt_q   <= cnt_d;
        saved_q <= saved_d;
        last_q  <= last_d;
        latch_q <= latch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign cnt_valid_o = v_q;
  assign cnt_o       = res_q;

endmodule

/* hw/rtl/imu_tsd_out.sv */
// ----------------------------------------------------------------------------
// IMU step detector output stage
// Scales the step total to distance and holds the result register.
// ----------------------------------------------------------------------------
module imu_tsd_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imu_tsd_pkg::cfg_t   cfg_i,
  input  logic                cnt_valid_i,
  output logic                cnt_ready_o,
  input  imu_tsd_pkg::count_t cnt_i,
  imu_tsd_result_if.source    result_if
);
  import imu_tsd_pkg::*;

  logic    v_q;
  result_t res_q, res_d;

  assign cnt_ready_o = !v_q || result_if.ready;

  always_comb begin
    res_d.step_seen    = cnt_i.step_seen;
    res_d.step_total   = cnt_i.step_total;
    res_d.save_request = cnt_i.save_request;
    res_d.distance_mm  = DistBits'(cnt_i.step_total) * DistBits'(cfg_i.step_length_mm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (cnt_ready_o) begin
      v_q <= cnt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_ready_o && cnt_valid_i) res_q <= res_d;
  end

  assign result_if.valid   = v_q;
  assign result_if.payload = res_q;

endmodule

/* hw/rtl/imu_threshold_step_detector_top.sv */
// ----------------------------------------------------------------------------
// IMU threshold step detector
// Counts steps from accelerometer and gyroscope samples.
// ----------------------------------------------------------------------------
// Takes one sample or clear request per clock cycle while the output is not
// stalled, and returns one result per request, in order. The path is a
// five-register pipeline: sample register, squaring stage (six multipliers),
// threshold compare, step state update, and the distance multiply feeding the
// result register. Only the step state stage carries state from one request
// to the next. Register writes are accepted in every cycle.
module imu_threshold_step_detector_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  imu_tsd_sample_if.sink   sample_if,
  imu_tsd_result_if.source result_if,
  imu_tsd_cfg_if.sink      cfg_if
);
  import imu_tsd_pkg::*;

  cfg_t   cfg_q;
  logic   flag_valid, flag_ready, cnt_valid, cnt_ready;
  flag_t  flag;
  count_t cnt;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acc_threshold   <= ThrBits'(9830);
      cfg_q.acc_rearm_level <= ThrBits'(8602);
      cfg_q.gyro_limit      <= ThrBits'(12800);
      cfg_q.step_delay_ms   <= DelayBits'(300);
      cfg_q.step_length_mm  <= LengthBits'(700);
      cfg_q.save_interval   <= IntvBits'(10);
    end else if (cfg_if.valid) begin
      case (cfg_idx_e'(cfg_if.index))
        CfgAccThreshold: cfg_q.acc_threshold   <= cfg_if.data[ThrBits-1:0];
        CfgAccRearm:     cfg_q.acc_rearm_level <= cfg_if.data[ThrBits-1:0];
        CfgGyroLimit:    cfg_q.gyro_limit      <= cfg_if.data[ThrBits-1:0];
        CfgStepDelay:    cfg_q.step_delay_ms   <= cfg_if.data[DelayBits-1:0];
        CfgStepLength:   cfg_q.step_length_mm  <= cfg_if.data[LengthBits-1:0];
        CfgSaveInterval: cfg_q.save_interval   <= cfg_if.data[IntvBits-1:0];
        default: ;
      endcase
    end
  end

  imu_tsd_mag u_mag (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_if    (sample_if),
    .cfg_i        (cfg_q),
    .flag_valid_o (flag_valid),
    .flag_ready_i (flag_ready),
    .flag_o       (flag)
  );

  imu_tsd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .flag_valid_i (flag_valid),
    .flag_ready_o (flag_ready),
    .flag_i       (flag),
    .cnt_valid_o  (cnt_valid),
    .cnt_ready_i  (cnt_ready),
    .cnt_o        (cnt)
  );

  imu_tsd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cnt_valid_i (cnt_valid),
    .cnt_ready_o (cnt_ready),
    .cnt_i       (cnt),
    .result_if   (result_if)
  );

endmodule

/* tb/sv/imu_tsd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU step detector checker
// Watches the sample, result and register channels. Tracks step count, save
// mark, last step time and re-arm latch for every accepted request, and
// compares each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module imu_tsd_checker
  import imu_tsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  imu_tsd_sample_if   sample_if,
  imu_tsd_result_if   result_if,
  imu_tsd_cfg_if      cfg_if,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned steps_o,
  output int unsigned saves_o
);

  localparam int unsigned ReportCap = 40;

  localparam cfg_t CfgAtReset = '{
    acc_threshold:   15'd9830,
    acc_rearm_level: 15'd8602,
    gyro_limit:      15'd12800,
    step_delay_ms:   16'd300,
    step_length_mm:  12'd700,
    save_interval:   16'd10
  };

  cfg_t                 regs;
  logic [CountBits-1:0] step_count;
  logic [CountBits-1:0] saved_count;
  logic [TimeBits-1:0]  last_step_ms;
  logic                 rearm_hold;
  result_t              expected_q[$];
  result_t              want;
  result_t              got;

  function automatic longint mag_sq(input logic signed [SampleBits-1:0] a,
                                    input logic signed [SampleBits-1:0] b,
                                    input logic signed [SampleBits-1:0] c);
    longint la;
    longint lb;
    longint lc;
    la = a;
    lb = b;
    lc = c;
    return la * la + lb * lb + lc * lc;
  endfunction

  function automatic result_t track_step(input sample_t s);
    result_t             r;
    longint              acc_sq;
    longint              gyr_sq;
    longint              thr_sq;
    longint              lim_sq;
    longint              rearm_sq;
    logic [TimeBits-1:0] elapsed;
    r = '0;
    if (s.cmd) begin
      step_count     = '0;
      saved_count    = '0;
      r.save_request = 1'b1;
    end else begin
      acc_sq   = mag_sq(s.acc_x, s.acc_y, s.acc_z);
      gyr_sq   = mag_sq(s.gyro_x, s.gyro_y, s.gyro_z);
      thr_sq   = longint'(regs.acc_threshold) * longint'(regs.acc_threshold);
      lim_sq   = longint'(regs.gyro_limit) * longint'(regs.gyro_limit);
      rearm_sq = longint'(regs.acc_rearm_level) * longint'(regs.acc_rearm_level);
      elapsed  = s.now_ms - last_step_ms;
      if (!rearm_hold && acc_sq > thr_sq && gyr_sq < lim_sq &&
          elapsed > TimeBits'(regs.step_delay_ms)) begin
        r.step_seen = 1'b1;
        if (step_count < StepMax) step_count = step_count + 1'b1;
        last_step_ms = s.now_ms;
        rearm_hold   = 1'b1;
        if (step_count != '0 && step_count >= saved_count &&
            (step_count - saved_count) >= CountBits'(regs.save_interval)) begin
          r.save_request = 1'b1;
          saved_count    = step_count;
        end
      end
      if (acc_sq < rearm_sq) rearm_hold = 1'b0;
    end
    r.step_total  = step_count;
    r.distance_mm = DistBits'(step_count) * DistBits'(regs.step_length_mm);
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input longint unsigned want_v,
                               input longint unsigned got_v);
    fail_count_o++;
    if (fail_count_o <= ReportCap)
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs         = CfgAtReset;
      step_count   = '0;
      saved_count  = '0;
      last_step_ms = '0;
      rearm_hold   = 1'b0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_e'(cfg_if.index))
          CfgAccThreshold: regs.acc_threshold   = cfg_if.data[ThrBits-1:0];
          CfgAccRearm:     regs.acc_rearm_level = cfg_if.data[ThrBits-1:0];
          CfgGyroLimit:    regs.gyro_limit      = cfg_if.data[ThrBits-1:0];
          CfgStepDelay:    regs.step_delay_ms   = cfg_if.data[DelayBits-1:0];
          CfgStepLength:   regs.step_length_mm  = cfg_if.data[LengthBits-1:0];
          CfgSaveInterval: regs.save_interval   = cfg_if.data[IntvBits-1:0];
          default: ;
        endcase
      end
      if (result_if.valid && result_if.ready) begin
        got = result_if.payload;
        results_o++;
        if (got.step_seen === 1'b1) steps_o++;
        if (got.save_request === 1'b1) saves_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportCap)
            $error("result with no request pending: step_total %0d", got.step_total);
        end else begin
          want = expected_q.pop_front();
          if (got.step_seen !== want.step_seen)
            flag_mismatch("step_seen", want.step_seen, got.step_seen);
          if (got.step_total !== want.step_total)
            flag_mismatch("step_total", want.step_total, got.step_total);
          if (got.distance_mm !== want.distance_mm)
            flag_mismatch("distance_mm", want.distance_mm, got.distance_mm);
          if (got.save_request !== want.save_request)
            flag_mismatch("save_request", want.save_request, got.save_request);
        end
      end
      if (sample_if.valid && sample_if.ready)
        expected_q.push_back(track_step(sample_if.payload));
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/sv/tb_imu_threshold_step_detector_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU threshold step detector testbench
// Drives directed edge cases and stride-shaped random IMU samples through
// several register settings and idle patterns, runs a burst of back-to-back
// steps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_imu_threshold_step_detector_top;
  import imu_tsd_pkg::*;

  localparam int unsigned HalfPeriod = 5;
  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned DrainWait  = 16;
  localparam int unsigned BurstSteps = 20;
  localparam logic [CfgIdxBits-1:0] SpareIdx = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  imu_tsd_sample_if sample_if ();
  imu_tsd_result_if result_if ();
  imu_tsd_cfg_if    cfg_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned steps_seen;
  int unsigned saves_seen;
  int unsigned cycle_count;
  int unsigned sample_count;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 46;

  int unsigned cur_thr   = 9830;
  int unsigned cur_rearm = 8602;
  int unsigned cur_gyro  = 12800;
  int unsigned cur_delay = 300;

  logic [TimeBits-1:0] walk_ms;
  int unsigned         stride_pos;
  int unsigned         stride_len = 4;

  imu_threshold_step_detector_top i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .sample_if (sample_if),
    .result_if (result_if),
    .cfg_if    (cfg_if)
  );

  imu_tsd_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .sample_if    (sample_if),
    .result_if    (result_if),
    .cfg_if       (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_seen),
    .steps_o      (steps_seen),
    .saves_o      (saves_seen)
  );

  always #HalfPeriod clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic sample_t motion_sample(input int ax, input int ay, input int az,
                                            input int gx, input int gy, input int gz,
                                            input logic [TimeBits-1:0] ms);
    sample_t s;
    s.cmd    = 1'b0;
    s.acc_x  = SampleBits'(ax);
    s.acc_y  = SampleBits'(ay);
    s.acc_z  = SampleBits'(az);
    s.gyro_x = SampleBits'(gx);
    s.gyro_y = SampleBits'(gy);
    s.gyro_z = SampleBits'(gz);
    s.now_ms = ms;
    return s;
  endfunction

  function automatic sample_t noise_sample(input logic cmd);
    sample_t s;
    s.cmd    = cmd;
    s.acc_x  = SampleBits'($urandom);
    s.acc_y  = SampleBits'($urandom);
    s.acc_z  = SampleBits'($urandom);
    s.gyro_x = SampleBits'($urandom);
    s.gyro_y = SampleBits'($urandom);
    s.gyro_z = SampleBits'($urandom);
    s.now_ms = $urandom;
    return s;
  endfunction

  // one dominant axis at the given magnitude, the other two jittered
  function automatic logic [3*SampleBits-1:0] axes(input int unsigned mag,
                                                   input int unsigned spread);
    logic [SampleBits-1:0] a[3];
    int                    main_axis;
    int                    v;
    main_axis = $urandom_range(2);
    for (int k = 0; k < 3; k++) begin
      if (k == main_axis) begin
        v = (mag > 32767) ? 32767 : int'(mag);
        if ($urandom_range(1)) v = (mag >= 32768) ? -32768 : -v;
      end else begin
        v = int'($urandom_range(2 * spread)) - int'(spread);
      end
      a[k] = SampleBits'(v);
    end
    return {a[0], a[1], a[2]};
  endfunction

  function automatic sample_t stride_sample();
    sample_t     s;
    int unsigned r;
    int unsigned mag;
    int unsigned lo;
    int unsigned hi;
    r = $urandom_range(99);
    if (r < 3) return noise_sample(1'b1);
    if (r < 12) begin
      s = noise_sample(1'b0);
      if ($urandom_range(1)) s.now_ms = walk_ms + $urandom_range(400);
      return s;
    end
    walk_ms = walk_ms + $urandom_range(1, cur_delay / 2 + 40);
    lo = (cur_rearm < cur_thr) ? cur_rearm : cur_thr;
    hi = (cur_rearm < cur_thr) ? cur_thr : cur_rearm;
    if (stride_pos == 0)
      mag = cur_thr + $urandom_range(4000);
    else if (stride_pos == 1 && $urandom_range(1))
      mag = $urandom_range(hi, lo);
    else if (cur_rearm == 0)
      mag = 0;
    else
      mag = cur_rearm - $urandom_range(1, (cur_rearm < 4000) ? cur_rearm : 4000);
    s.cmd = 1'b0;
    {s.acc_x, s.acc_y, s.acc_z} = axes(mag, 300);
    if ($urandom_range(99) < 15)
      mag = cur_gyro + $urandom_range(3000);
    else
      mag = $urandom_range(cur_gyro * 3 / 4);
    {s.gyro_x, s.gyro_y, s.gyro_z} = axes(mag, 100);
    s.now_ms = walk_ms;
    stride_pos++;
    if (stride_pos >= stride_len) begin
      stride_pos = 0;
      stride_len = $urandom_range(2, 6);
    end
    return s;
  endfunction

  task automatic push_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(negedge clk);
    end
    sample_if.valid   <= 1'b1;
    sample_if.payload <= s;
    do @(posedge clk); while (!sample_if.ready);
    @(negedge clk);
    sample_count++;
  endtask

  task automatic wait_drained();
    sample_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    case (cfg_idx_e'(idx))
      CfgAccThreshold: cur_thr   = value[ThrBits-1:0];
      CfgAccRearm:     cur_rearm = value[ThrBits-1:0];
      CfgGyroLimit:    cur_gyro  = value[ThrBits-1:0];
      CfgStepDelay:    cur_delay = value[DelayBits-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CfgDataBits-1:0] thr,
                              input logic [CfgDataBits-1:0] rearm,
                              input logic [CfgDataBits-1:0] gyro,
                              input logic [CfgDataBits-1:0] delay,
                              input logic [CfgDataBits-1:0] len,
                              input logic [CfgDataBits-1:0] intv);
    wait_drained();
    write_reg(CfgAccThreshold, thr);
    write_reg(CfgAccRearm, rearm);
    write_reg(CfgGyroLimit, gyro);
    write_reg(CfgStepDelay, delay);
    write_reg(CfgStepLength, len);
    write_reg(CfgSaveInterval, intv);
    write_reg(SpareIdx, CfgDataBits'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_strides(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(199) == 0) wait_drained();
      push_sample(stride_sample());
    end
  endtask

  initial begin
    logic [TimeBits-1:0] ms;
    sample_if.valid   = 1'b0;
    sample_if.payload = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // power-on settings: edges of every step condition
    push_sample(noise_sample(1'b1));
    push_sample(motion_sample(-32768, -32768, -32768, 0, 0, 0, 32'd1000));
    push_sample(motion_sample(32767, 32767, 32767, 0, 0, 0, 32'd1100));
    push_sample(motion_sample(0, 0, 8602, 0, 0, 0, 32'd1200));
    push_sample(motion_sample(0, 0, 8601, 0, 0, 0, 32'd1250));
    push_sample(motion_sample(9830, 0, 0, 0, 0, 0, 32'd2000));
    push_sample(motion_sample(0, 0, 9831, 12800, 0, 0, 32'd2000));
    push_sample(motion_sample(0, -9831, 0, 0, 0, -12799, 32'd1300));
    push_sample(motion_sample(0, -9831, 0, 0, 0, -12799, 32'd1301));
    push_sample(motion_sample(0, 0, 0, -32768, -32768, -32768, 32'd1400));
    push_sample(motion_sample(20000, 0, 0, 32767, 0, 0, 32'd2000));
    push_sample(motion_sample(0, 20000, 0, 0, 0, 0, 32'hFFFF_FFF0));
    push_sample(motion_sample(0, 0, 100, 0, 0, 0, 32'h0000_0010));
    push_sample(motion_sample(0, 0, 20000, 0, 0, 0, 32'h0000_0050));
    push_sample(motion_sample(0, 0, 20000, 0, 0, 0, 32'h0000_0200));
    push_sample(noise_sample(1'b1));
    push_sample(motion_sample(0, 0, 0, 0, 0, 0, 32'h0000_0400));
    push_sample(motion_sample(-20000, 0, 0, 0, 0, 0, 32'h0000_0800));

    walk_ms = $urandom;
    run_strides(250);

    // re-arm above threshold, no delay, save on every step
    program_regs(16'd0, 16'd32767, 16'd32767, 16'd0, 16'd4095, 16'd0);
    ms = walk_ms;
    push_sample(motion_sample(1, 0, 0, 0, 0, 0, ms + 1));
    push_sample(motion_sample(0, 0, -1, 0, 0, 0, ms + 1));
    push_sample(motion_sample(0, 0, 0, 0, 0, 0, ms + 2));
    push_sample(motion_sample(0, 2, 0, 0, 0, 0, ms + 3));
    walk_ms = ms + 3;
    run_strides(150);

    wait_drained();
    send_idle_pct = 46;
    recv_idle_pct = 35;
    program_regs({1'($urandom), 15'($urandom_range(16000, 6000))},
                 {1'($urandom), 15'($urandom_range(9000, 3000))},
                 {1'($urandom), 15'($urandom_range(20000, 2000))},
                 16'($urandom_range(400)),
                 {4'($urandom), 12'($urandom)},
                 16'($urandom_range(20, 1)));
    run_strides(250);

    program_regs(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    run_strides(100);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'd9830, 16'd8602, 16'd12800, 16'($urandom_range(350, 150)),
                 16'd700, 16'd10);
    walk_ms = 32'hFFFF_FFFF - $urandom_range(20000);
    run_strides(250);

    // step on every request with no save due, then clear
    program_regs(16'd0, 16'd32767, 16'd32767, 16'd0, 16'd4095, 16'hFFFF);
    push_sample(noise_sample(1'b1));
    for (int unsigned i = 0; i < BurstSteps; i++)
      push_sample(motion_sample(0, 100, 0, 0, 0, 0, walk_ms + i + 1));
    walk_ms = walk_ms + BurstSteps;
    push_sample(noise_sample(1'b1));
    run_strides(30);

    wait_drained();
    repeat (DrainWait) @(negedge clk);
    $display("Drove %0d samples over six register settings and three idle patterns,",
             sample_count);
    $display("with clears and wrapping time: %0d results, %0d steps, %0d save requests.",
             results_seen, steps_seen, saves_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
